[rtl/core/distance_vector_route_update_defines.svh]
// Assertion macros for the checker file of the route update block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DVRU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dvru check failed");

// next-cycle implication, disabled during reset
`define DVRU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dvru check failed");

`endif

[rtl/core/dvru_pkg.sv]
// Shared widths, codes and constants of the distance-vector route update block.
// No dependencies.
package dvru_pkg;

	localparam int ID_W     = 4;
	localparam int COST_W   = 7;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd1;

	localparam logic [ID_W-1:0] LOCAL_ID_RST   = 4'd1;
	localparam logic [ID_W-1:0] NODE_COUNT_RST = 4'd5;

	localparam logic [COST_W-1:0] UNREACH = 7'd99;

	localparam logic [CMD_W-1:0] CMD_NEIGHBOR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LINK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT     = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LOCAL = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_SELF     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_DEST = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_COST_HIGH = 3'd4;

endpackage

[rtl/core/distance_vector_route_update.sv]
// Distance-vector route table: link-cost matrix in RAM, route table in flops.
// Depends on dvru_pkg and dvru_ram.
//
// Usage. Requests arrive on the s_ side: tuser carries the command, tlast
// marks the final entry of a neighbour vector. Route rows leave on the m_
// side, tlast set on the final row of a request. The user must write local_id
// and node_count through cfg_we/cfg_index/cfg_data while the block is idle.
// The block does not enforce this. Steps, with n the nodes in use:
//   neighbour entry without tlast: matrix write in EXEC, no row.
//   init link: EXEC, then INIT2 for the reverse entry if valid; no row.
//   link update: one row, loaded into the output register in ROW1 after
//   EXEC once the output is free; the block is idle again on the same cycle.
//   neighbour entry with tlast: per node i, LI, LJ0 and REL over n columns,
//   one read and add/compare per REL cycle; then n rows, one per free cycle.
// s_tready is high only in the idle state, so one request is worked at a
// time; the output register may still hold the last row while the next
// request is taken. If m_tready stays low, row emission waits.
// Reset: matrix reads as 0 on the diagonal and 99 elsewhere through per-entry
// valid flags, route costs 99, next hops 0, local_id 1, node_count 5. No
// clearing pass is needed.
module distance_vector_route_update import dvru_pkg::*; #(
	parameter int MAX_NODES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sender_id[3:0], dest_id[7:4], cost[14:8]
	input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // dest_out[3:0], next_hop[7:4], path_cost[14:8], status[17:15]
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = ID_W + 1;
	localparam int PAD_W = OUT_DATA_W - (2 * ID_W + COST_W + STATUS_W);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_INIT2 = 3'd2;
	localparam logic [2:0] ST_ROW1  = 3'd3;
	localparam logic [2:0] ST_LI    = 3'd4;
	localparam logic [2:0] ST_LJ0   = 3'd5;
	localparam logic [2:0] ST_REL   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0]          state_q;
	logic [ID_W-1:0]     local_id_q;
	logic [ID_W-1:0]     node_count_q;

	logic [CMD_W-1:0]    cmd_q;
	logic [ID_W-1:0]     snd_q;
	logic [ID_W-1:0]     dst_q;
	logic [COST_W-1:0]   cost_q;
	logic                last_q;
	logic [STATUS_W-1:0] status_q;
	logic [COST_W-1:0]   li_q;
	logic [NW-1:0]       i_q;
	logic [NW-1:0]       j_q;

	logic [COST_W-1:0]   route_cost_q [MAX_NODES];
	logic [ID_W-1:0]     route_next_q [MAX_NODES];
	logic [DEPTH-1:0]    valid_q;

	logic                out_valid_q;
	logic [ID_W-1:0]     out_dest_q;
	logic [ID_W-1:0]     out_hop_q;
	logic [COST_W-1:0]   out_cost_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_last_q;

	logic                rd_vld_s1;
	logic                rd_diag_s1;

	logic [XW-1:0]       n_use;
	logic                loc_ok, snd_ok, dst_ok, init_ok;
	logic [ID_W-1:0]     loc_m1, snd_m1, dst_m1;
	logic [NW-1:0]       loc_idx, snd_idx, dst_idx;
	logic [COST_W-1:0]   sat_cost;
	logic [STATUS_W-1:0] status_c;
	logic                j_end, i_end, out_free, out_load;
	logic [ID_W-1:0]     j_id;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COST_W-1:0]   ram_wdata;
	logic [NW-1:0]       rd_row, rd_col;
	logic [AW-1:0]       ram_raddr;
	logic [COST_W-1:0]   ram_rdata;
	logic [COST_W-1:0]   rd_eff;
	logic [COST_W:0]     via;

	function automatic logic [AW-1:0] mk_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
		return AW'(AW'(r) * AW'(MAX_NODES) + AW'(c));
	endfunction

	always_comb begin
		if (node_count_q == '0) begin
			n_use = XW'(1);
		end else if (XW'(node_count_q) > XW'(MAX_NODES)) begin
			n_use = XW'(MAX_NODES);
		end else begin
			n_use = XW'(node_count_q);
		end
	end

	assign loc_ok  = (local_id_q != '0) && (XW'(local_id_q) <= n_use);
	assign snd_ok  = (snd_q != '0) && (XW'(snd_q) <= n_use);
	assign dst_ok  = (dst_q != '0) && (XW'(dst_q) <= n_use);
	assign init_ok = loc_ok && dst_ok && (dst_q != local_id_q);

	assign loc_m1  = local_id_q - ID_W'(1);
	assign snd_m1  = snd_q - ID_W'(1);
	assign dst_m1  = dst_q - ID_W'(1);
	assign loc_idx = loc_m1[NW-1:0];
	assign snd_idx = snd_m1[NW-1:0];
	assign dst_idx = dst_m1[NW-1:0];

	assign sat_cost = (cost_q > UNREACH) ? UNREACH : cost_q;

	always_comb begin
		priority if (snd_q != local_id_q || !loc_ok) begin
			status_c = STATUS_NOT_LOCAL;
		end else if (dst_q == local_id_q) begin
			status_c = STATUS_SELF;
		end else if (!dst_ok) begin
			status_c = STATUS_BAD_DEST;
		end else if (cost_q > UNREACH) begin
			status_c = STATUS_COST_HIGH;
		end else begin
			status_c = STATUS_OK;
		end
	end

	assign j_end    = (XW'(j_q) == n_use - XW'(1));
	assign i_end    = (XW'(i_q) == n_use - XW'(1));
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (state_q == ST_ROW1 || state_q == ST_EMIT);
	assign j_id     = ID_W'(j_q) + ID_W'(1);

	// matrix write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mk_addr(loc_idx, dst_idx);
		ram_wdata = sat_cost;
		unique case (state_q)
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_NEIGHBOR: begin
						ram_we    = snd_ok && dst_ok;
						ram_waddr = mk_addr(snd_idx, dst_idx);
					end
					CMD_LINK: begin
						ram_we    = (status_c == STATUS_OK);
						ram_wdata = cost_q;
					end
					CMD_INIT: begin
						ram_we = init_ok;
					end
					default: begin
						ram_we = 1'b0;
					end
				endcase
			end
			ST_INIT2: begin
				ram_we    = 1'b1;
				ram_waddr = mk_addr(dst_idx, loc_idx);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// matrix read port
	always_comb begin
		rd_row = '0;
		rd_col = '0;
		unique case (state_q)
			ST_LI: begin
				rd_row = loc_idx;
				rd_col = i_q;
			end
			ST_LJ0: begin
				rd_row = i_q;
			end
			ST_REL: begin
				rd_row = i_q;
				rd_col = j_q + NW'(1);
			end
			default: begin
				rd_row = '0;
			end
		endcase
	end

	assign ram_raddr = mk_addr(rd_row, rd_col);
	assign rd_eff    = rd_vld_s1 ? ram_rdata : (rd_diag_s1 ? '0 : UNREACH);
	assign via       = {1'b0, li_q} + {1'b0, rd_eff};

	dvru_ram #(
		.WIDTH(COST_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1  <= valid_q[ram_raddr];
		rd_diag_s1 <= (rd_row == rd_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id_q   <= LOCAL_ID_RST;
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_LOCAL_ID) begin
				local_id_q <= cfg_data[ID_W-1:0];
			end else if (cfg_index == REG_NODE_COUNT) begin
				node_count_q <= cfg_data[ID_W-1:0];
			end
		end
	end

	// request fields and working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q  <= s_tuser;
			snd_q  <= s_tdata[ID_W-1:0];
			dst_q  <= s_tdata[2*ID_W-1:ID_W];
			cost_q <= s_tdata[2*ID_W+COST_W-1:2*ID_W];
			last_q <= s_tlast;
		end
		if (state_q == ST_EXEC) begin
			status_q <= status_c;
		end
		if (state_q == ST_LJ0) begin
			li_q <= rd_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			for (int k = 0; k < MAX_NODES; k++) begin
				route_cost_q[k] <= UNREACH;
				route_next_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_NEIGHBOR: begin
							i_q <= '0;
							j_q <= '0;
							if (!last_q) begin
								state_q <= ST_IDLE;
							end else if (loc_ok) begin
								state_q <= ST_LI;
							end else begin
								state_q <= ST_EMIT;
							end
						end
						CMD_LINK: begin
							if (status_c == STATUS_OK) begin
								route_cost_q[dst_idx] <= cost_q;
							end
							state_q <= ST_ROW1;
						end
						CMD_INIT: begin
							if (init_ok) begin
								route_cost_q[dst_idx] <= sat_cost;
								route_next_q[dst_idx] <= dst_q;
								state_q <= ST_INIT2;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_INIT2: begin
					state_q <= ST_IDLE;
				end
				ST_ROW1: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LI: begin
					state_q <= ST_LJ0;
				end
				ST_LJ0: begin
					j_q     <= '0;
					state_q <= ST_REL;
				end
				ST_REL: begin
					if (via < {1'b0, route_cost_q[j_q]}) begin
						route_cost_q[j_q] <= via[COST_W-1:0];
						route_next_q[j_q] <= ID_W'(i_q) + ID_W'(1);
					end
					if (j_end) begin
						j_q <= '0;
						if (i_end) begin
							state_q <= ST_EMIT;
						end else begin
							i_q     <= i_q + NW'(1);
							state_q <= ST_LI;
						end
					end else begin
						j_q <= j_q + NW'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						j_q <= j_q + NW'(1);
						if (j_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output row payload
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW1 && out_free) begin
			out_dest_q   <= dst_q;
			out_hop_q    <= dst_ok ? route_next_q[dst_idx] : '0;
			out_cost_q   <= dst_ok ? route_cost_q[dst_idx] : UNREACH;
			out_status_q <= status_q;
			out_last_q   <= 1'b1;
		end else if (state_q == ST_EMIT && out_free) begin
			out_dest_q   <= j_id;
			out_hop_q    <= route_next_q[j_q];
			out_cost_q   <= route_cost_q[j_q];
			out_status_q <= STATUS_OK;
			out_last_q   <= j_end;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_status_q, out_cost_q, out_hop_q, out_dest_q};
	assign m_tlast  = out_last_q;

endmodule

[rtl/core/dvru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/dvru_checker.sv]
// Port-level checks of the distance-vector route update block, bound to the top.
// Depends on dvru_pkg and distance_vector_route_update_defines.svh.
`include "distance_vector_route_update_defines.svh"

module dvru_checker import dvru_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,   // dest_out[3:0], next_hop[7:4], path_cost[14:8], status[17:15]
	input logic                  m_tlast
);

	`DVRU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`DVRU_ASSERT_NXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	`DVRU_ASSERT_IMP(a_cost_range, m_tvalid, m_tdata[14:8] <= UNREACH)
	`DVRU_ASSERT_IMP(a_status_single, m_tvalid && m_tdata[17:15] != STATUS_OK, m_tlast)
	`DVRU_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
